// ----- rtl/hcb_pkg.sv -----
// Package for the Huffman code builder: sizes, command codes, state encoding.
// Used by huffman_tree_code_builder_top and the testbench.
`default_nettype none
package hcb_pkg;

  localparam int unsigned MaxLeaves = 256;
  localparam int unsigned LeafAw    = $clog2(MaxLeaves);
  localparam int unsigned NodeDepth = 2 * MaxLeaves;
  localparam int unsigned NodeAw    = $clog2(NodeDepth);
  localparam int unsigned CountW    = LeafAw + 1;
  localparam int unsigned CodeW     = 48;
  localparam int unsigned LenW      = 6;
  localparam int unsigned MaxCodeLen = 48;
  localparam int unsigned CodeLimit = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;
  localparam int unsigned WeightW   = 32;
  localparam int unsigned SymW      = 8;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned CodeEntW  = CodeW + LenW + 1;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_READ   = 9'b000000010,
    ST_CLEAR  = 9'b000000100,
    ST_SCAN   = 9'b000001000,
    ST_MRG_A  = 9'b000010000,
    ST_MRG_B  = 9'b000100000,
    ST_WALK_P = 9'b001000000,
    ST_WALK_L = 9'b010000000,
    ST_WALK_C = 9'b100000000
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/hcb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hcb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/huffman_tree_code_builder_top.sv -----
// Huffman tree and code builder top level.
// Depends on hcb_pkg and hcb_ram.
// Load and unknown commands are accepted back to back in ST_IDLE; a pending result holds them off.
// A read passes through ST_READ, where the registered RAM read data is captured into the output
// registers, and the input is held off meanwhile. A build clears the linked flags of its 2n node
// entries, then per merge scans the nodes (one node per cycle through the RAM read port) and writes
// in ST_MRG_A and ST_MRG_B, then per leaf walks ST_WALK_P, ST_WALK_L, ST_WALK_C per tree level and stores the code.
// Reset clears control state only; RAMs are not cleared.
`default_nettype none
module huffman_tree_code_builder_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [hcb_pkg::CmdW-1:0]    command_i,
  input  wire logic [hcb_pkg::SymW-1:0]    symbol_i,
  input  wire logic [hcb_pkg::WeightW-1:0] weight_i,
  input  wire logic [hcb_pkg::LeafAw-1:0]  entry_index_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [hcb_pkg::SymW-1:0]    out_symbol_o,
  output logic      [hcb_pkg::CodeW-1:0]   code_bits_o,
  output logic      [hcb_pkg::LenW-1:0]    code_length_o,
  output logic      [hcb_pkg::CountW-1:0]  leaf_count_o,
  output logic                             overflow_o
);
  import hcb_pkg::*;

  state_e st_q, st_d;
  logic [CountW-1:0] n_q, n_d;
  logic              built_q, built_d;
  logic [NodeAw-1:0] tot_q, tot_d;
  logic [NodeAw-1:0] i_q, i_d, j_q, j_d, pj_q, pj_d;
  logic              pv_q, pv_d, va_q, va_d, vb_q, vb_d;
  logic [NodeAw-1:0] a_q, a_d, b_q, b_d;
  logic [WeightW-1:0] wa_q, wa_d, wb_q, wb_d;
  logic [NodeAw-1:0] c_q, c_d, p_q, p_d;
  logic [NodeAw-1:0] len_q, len_d;
  logic [CodeW-1:0]  code_q, code_d;
  logic [LeafAw-1:0] l_q, l_d;
  logic              rok_q, rok_d;
  logic              ov_q, ov_d;
  logic [SymW-1:0]   osym_q, osym_d;
  logic [CodeW-1:0]  obits_q, obits_d;
  logic [LenW-1:0]   olen_q, olen_d;
  logic [CountW-1:0] ocnt_q, ocnt_d;
  logic              oov_q, oov_d;

  logic              acc;
  logic [NodeAw:0]   tot_full;
  logic [WeightW:0]  sum;
  logic [CountW-1:0] ld_idx;

  // RAM ports
  logic               wt_we, lk_we, pa_we, lf_we, sy_we, cd_we;
  logic [NodeAw-1:0]  wt_wa, lk_wa, pa_wa, wt_ra, pa_ra, lf_ra;
  logic [WeightW-1:0] wt_wd, wt_rd;
  logic               lk_wd, lk_rd;
  logic [NodeAw-1:0]  pa_rd, lf_rd;
  logic [CodeEntW-1:0] cd_wd, cd_rd;
  logic [SymW-1:0]    sy_rd;

  hcb_ram #(.Width(WeightW), .Depth(NodeDepth)) u_weight (
    .clk_i, .we_i(wt_we), .waddr_i(wt_wa), .wdata_i(wt_wd), .raddr_i(wt_ra), .rdata_o(wt_rd));
  hcb_ram #(.Width(1), .Depth(NodeDepth)) u_linked (
    .clk_i, .we_i(lk_we), .waddr_i(lk_wa), .wdata_i(lk_wd), .raddr_i(wt_ra), .rdata_o(lk_rd));
  hcb_ram #(.Width(NodeAw), .Depth(NodeDepth)) u_parent (
    .clk_i, .we_i(pa_we), .waddr_i(pa_wa), .wdata_i(i_q), .raddr_i(pa_ra), .rdata_o(pa_rd));
  hcb_ram #(.Width(NodeAw), .Depth(NodeDepth)) u_left (
    .clk_i, .we_i(lf_we), .waddr_i(i_q), .wdata_i(a_q), .raddr_i(lf_ra), .rdata_o(lf_rd));
  hcb_ram #(.Width(SymW), .Depth(MaxLeaves)) u_symbol (
    .clk_i, .we_i(sy_we), .waddr_i(ld_idx[LeafAw-1:0]), .wdata_i(symbol_i),
    .raddr_i(entry_index_i), .rdata_o(sy_rd));
  hcb_ram #(.Width(CodeEntW), .Depth(MaxLeaves)) u_code (
    .clk_i, .we_i(cd_we), .waddr_i(l_q), .wdata_i(cd_wd),
    .raddr_i(entry_index_i), .rdata_o(cd_rd));

  assign in_ready_o = (st_q == ST_IDLE) && (!out_valid_o || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;
  assign tot_full   = {n_q, 1'b0} - {{NodeAw{1'b0}}, 1'b1};
  assign sum        = {1'b0, wa_q} + {1'b0, wb_q};
  assign ld_idx     = built_q ? '0 : n_q;

  always_comb begin
    st_d = st_q; n_d = n_q; built_d = built_q; tot_d = tot_q;
    i_d = i_q; j_d = j_q; pj_d = pj_q; pv_d = 1'b0;
    va_d = va_q; vb_d = vb_q; a_d = a_q; b_d = b_q; wa_d = wa_q; wb_d = wb_q;
    c_d = c_q; p_d = p_q; len_d = len_q; code_d = code_q; l_d = l_q;
    rok_d = rok_q; ov_d = ov_q;
    osym_d = osym_q; obits_d = obits_q; olen_d = olen_q; ocnt_d = ocnt_q; oov_d = oov_q;
    wt_we = 1'b0; wt_wa = ld_idx; wt_wd = weight_i; wt_ra = j_q;
    lk_we = 1'b0; lk_wa = a_q; lk_wd = 1'b1;
    pa_we = 1'b0; pa_wa = a_q; pa_ra = c_q;
    lf_we = 1'b0; lf_ra = pa_rd;
    sy_we = 1'b0; cd_we = 1'b0;
    cd_wd = {code_q, len_q[LenW-1:0], 1'b0};
    if (len_q > NodeAw'(CodeLimit)) begin
      cd_wd = {{(CodeW + LenW){1'b0}}, 1'b1};
    end
    ov_d = out_valid_o && !out_ready_i;

    unique case (st_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (cmd_e'(command_i))
            CMD_LOAD: begin
              built_d = 1'b0;
              if (ld_idx < CountW'(MaxLeaves)) begin
                wt_we = 1'b1;
                sy_we = 1'b1;
                n_d   = ld_idx + 1'b1;
              end else begin
                n_d = ld_idx;
              end
            end
            CMD_BUILD: begin
              tot_d = tot_full[NodeAw-1:0];
              j_d   = '0;
              if (n_q == '0) begin
                built_d = 1'b1;
              end else begin
                st_d = ST_CLEAR;
              end
            end
            CMD_READ: begin
              rok_d  = built_q && ({1'b0, entry_index_i} < n_q);
              ocnt_d = n_q;
              st_d   = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        osym_d  = rok_q ? sy_rd : '0;
        obits_d = rok_q ? cd_rd[CodeEntW-1 -: CodeW] : '0;
        olen_d  = rok_q ? cd_rd[LenW:1] : '0;
        oov_d   = rok_q ? cd_rd[0] : 1'b0;
        ov_d    = 1'b1;
        st_d    = ST_IDLE;
      end
      ST_CLEAR: begin
        lk_we = 1'b1;
        lk_wa = j_q;
        lk_wd = 1'b0;
        j_d   = j_q + 1'b1;
        if (j_q == tot_q) begin
          j_d  = '0;
          i_d  = n_q[NodeAw-1:0];
          va_d = 1'b0;
          vb_d = 1'b0;
          l_d  = '0;
          c_d  = '0;
          len_d = '0;
          code_d = '0;
          st_d = (tot_q == NodeAw'(1)) ? ST_WALK_P : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (j_q != i_q) begin
          pv_d = 1'b1;
          pj_d = j_q;
          j_d  = j_q + 1'b1;
        end
        // compare the node read last cycle
        if (pv_q && !lk_rd) begin
          if (!va_q || wt_rd < wa_q) begin
            b_d = a_q; wb_d = wa_q; vb_d = va_q;
            a_d = pj_q; wa_d = wt_rd; va_d = 1'b1;
          end else if (!vb_q || wt_rd < wb_q) begin
            b_d = pj_q; wb_d = wt_rd; vb_d = 1'b1;
          end
        end
        if (j_q == i_q && !pv_q) begin
          st_d = ST_MRG_A;
        end
      end
      ST_MRG_A: begin
        wt_we = 1'b1;
        wt_wa = i_q;
        wt_wd = sum[WeightW] ? {WeightW{1'b1}} : sum[WeightW-1:0];
        lf_we = 1'b1;
        pa_we = 1'b1;
        lk_we = 1'b1;
        st_d  = ST_MRG_B;
      end
      ST_MRG_B: begin
        pa_we = 1'b1;
        pa_wa = b_q;
        lk_we = 1'b1;
        lk_wa = b_q;
        i_d   = i_q + 1'b1;
        j_d   = '0;
        va_d  = 1'b0;
        vb_d  = 1'b0;
        st_d  = (i_q == tot_q - 1'b1) ? ST_WALK_P : ST_SCAN;
      end
      ST_WALK_P: begin
        if (c_q == tot_q - 1'b1) begin
          cd_we  = 1'b1;
          l_d    = l_q + 1'b1;
          c_d    = NodeAw'(l_q) + 1'b1;
          len_d  = '0;
          code_d = '0;
          if ({1'b0, l_q} == n_q - 1'b1) begin
            built_d = 1'b1;
            st_d    = ST_IDLE;
          end
        end else begin
          st_d = ST_WALK_L;
        end
      end
      ST_WALK_L: begin
        p_d  = pa_rd;
        st_d = ST_WALK_C;
      end
      ST_WALK_C: begin
        if (lf_rd != c_q && len_q < NodeAw'(CodeW)) begin
          code_d = code_q | (CodeW'(1) << len_q[LenW-1:0]);
        end
        len_d = len_q + 1'b1;
        c_d   = p_q;
        st_d  = ST_WALK_P;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      n_q     <= '0;
      built_q <= 1'b0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      n_q     <= n_d;
      built_q <= built_d;
      pv_q    <= pv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tot_q <= tot_d; i_q <= i_d; j_q <= j_d; pj_q <= pj_d;
    va_q <= va_d; vb_q <= vb_d; a_q <= a_d; b_q <= b_d; wa_q <= wa_d; wb_q <= wb_d;
    c_q <= c_d; p_q <= p_d; len_q <= len_d; code_q <= code_d; l_q <= l_d;
    rok_q <= rok_d;
    osym_q <= osym_d; obits_q <= obits_d; olen_q <= olen_d; ocnt_q <= ocnt_d;
    oov_q <= oov_d;
  end

  assign out_valid_o   = ov_q;
  assign out_symbol_o  = osym_q;
  assign code_bits_o   = obits_q;
  assign code_length_o = olen_q;
  assign leaf_count_o  = ocnt_q;
  assign overflow_o    = oov_q;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for huffman_tree_code_builder_top: random and directed leaf sets, builds and reads.
// Holds its own tree predictor in a scoreboard class; depends on hcb_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
  import hcb_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned Nodes = 2 * MaxLeaves - 1;

  typedef struct packed {
    logic [SymW-1:0]   sym;
    logic [CodeW-1:0]  code;
    logic [LenW-1:0]   len;
    logic [CountW-1:0] count;
    logic              ovf;
  } code_rd_t;

  class code_scoreboard;
    logic [WeightW-1:0] node_wt[Nodes];
    logic [NodeAw-1:0]  node_par[Nodes];
    logic [NodeAw-1:0]  node_lft[Nodes];
    logic [SymW-1:0]    leaf_sym[MaxLeaves];
    logic [CodeW-1:0]   leaf_code[MaxLeaves];
    logic [LenW-1:0]    leaf_len[MaxLeaves];
    logic               leaf_ovf[MaxLeaves];
    int unsigned        held;
    bit                 built;
    code_rd_t           code_reads[$];
    int unsigned        errors;
    int unsigned        reads_checked;

    function void build_codes();
      bit          linked[Nodes];
      int unsigned n, total, a, b, c, depth;
      bit          va, vb;
      logic [32:0] sum;
      logic [CodeW-1:0] cw;
      n = held;
      if (n == 0) return;
      total = 2 * n - 1;
      foreach (linked[k]) linked[k] = 0;
      for (int unsigned i = n; i < total; i++) begin
        va = 0; vb = 0; a = 0; b = 0;
        for (int unsigned j = 0; j < i; j++) begin
          if (linked[j]) continue;
          if (!va || node_wt[j] < node_wt[a]) begin
            b = a; vb = va; a = j; va = 1;
          end else if (!vb || node_wt[j] < node_wt[b]) begin
            b = j; vb = 1;
          end
        end
        sum = {1'b0, node_wt[a]} + {1'b0, node_wt[b]};
        node_wt[i] = sum[32] ? 32'hffffffff : sum[31:0];
        node_lft[i] = NodeAw'(a);
        node_par[a] = NodeAw'(i);
        node_par[b] = NodeAw'(i);
        linked[a] = 1;
        linked[b] = 1;
      end
      for (int unsigned i = 0; i < n; i++) begin
        c = i; depth = 0; cw = '0;
        while (c != total - 1) begin
          if (node_lft[node_par[c]] != c && depth < CodeW) cw[depth] = 1'b1;
          depth++;
          c = node_par[c];
        end
        if (depth > CodeLimit) begin
          leaf_code[i] = '0; leaf_len[i] = '0; leaf_ovf[i] = 1'b1;
        end else begin
          leaf_code[i] = cw; leaf_len[i] = LenW'(depth); leaf_ovf[i] = 1'b0;
        end
      end
    endfunction

    function void note_input(cmd_e cmd, logic [SymW-1:0] s, logic [WeightW-1:0] w,
                             logic [LeafAw-1:0] idx);
      code_rd_t r;
      case (cmd)
        CMD_LOAD: begin
          if (built) begin
            held = 0; built = 0;
          end
          if (held < MaxLeaves) begin
            leaf_sym[held] = s;
            node_wt[held] = w;
            held++;
          end
        end
        CMD_BUILD: begin
          build_codes();
          built = 1;
        end
        CMD_READ: begin
          r = '0;
          r.count = CountW'(held);
          if (built && idx < held) begin
            r.sym = leaf_sym[idx]; r.code = leaf_code[idx];
            r.len = leaf_len[idx]; r.ovf = leaf_ovf[idx];
          end
          code_reads.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(code_rd_t got);
      code_rd_t exp_r;
      reads_checked++;
      if (code_reads.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: %p", got);
        return;
      end
      exp_r = code_reads.pop_front();
      if (got.sym !== exp_r.sym || got.code !== exp_r.code || got.len !== exp_r.len ||
          got.count !== exp_r.count || got.ovf !== exp_r.ovf) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: sym %h/%h code %h/%h len %0d/%0d count %0d/%0d ovf %b/%b",
                   exp_r.sym, got.sym, exp_r.code, got.code, exp_r.len, got.len,
                   exp_r.count, got.count, exp_r.ovf, got.ovf);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CmdW-1:0] command_i = CMD_NONE;
  logic [SymW-1:0] symbol_i = '0;
  logic [WeightW-1:0] weight_i = '0;
  logic [LeafAw-1:0] entry_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [SymW-1:0] out_symbol_o;
  logic [CodeW-1:0] code_bits_o;
  logic [LenW-1:0] code_length_o;
  logic [CountW-1:0] leaf_count_o;
  logic overflow_o;

  huffman_tree_code_builder_top dut (.*);

  always #5 clk_i = ~clk_i;

  code_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned builds_sent = 0;
  int unsigned burst_left = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: checks each result taken and rotates through three stall modes
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_result(code_rd_t'{out_symbol_o, code_bits_o, code_length_o, leaf_count_o,
                                 overflow_o});
    case ((cycles / 64) % 3)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      default: out_ready_i <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic send(cmd_e cmd, logic [SymW-1:0] s, logic [WeightW-1:0] w,
                      logic [LeafAw-1:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    symbol_i <= s;
    weight_i <= w;
    entry_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, s, w, idx);
    items_sent++;
    if (cmd == CMD_BUILD) builds_sent++;
  endtask

  task automatic load(logic [SymW-1:0] s, logic [WeightW-1:0] w);
    send(CMD_LOAD, s, w, LeafAw'($urandom));
  endtask

  task automatic read_entry(logic [LeafAw-1:0] idx);
    send(CMD_READ, SymW'($urandom), $urandom, idx);
  endtask

  task automatic build();
    send(CMD_BUILD, SymW'($urandom), $urandom, LeafAw'($urandom));
  endtask

  function automatic logic [WeightW-1:0] rand_weight(int unsigned mode);
    logic [WeightW-1:0] w;
    case (mode)
      0: w = $urandom_range(1, 4);
      1: w = 32'hffffffff - $urandom_range(0, 3);
      default: w = $urandom;
    endcase
    return (w == 0) ? 1 : w;
  endfunction

  task automatic random_set(int unsigned n);
    int unsigned mode;
    mode = $urandom_range(0, 2);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        send(CMD_NONE, SymW'($urandom), $urandom, LeafAw'($urandom));
      load(SymW'($urandom),
           rand_weight($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : mode));
    end
    if ($urandom_range(0, 9) == 0) read_entry(LeafAw'($urandom_range(0, n)));
    build();
    if ($urandom_range(0, 7) == 0) build();
    for (int unsigned i = 0; i < n + 2; i++)
      read_entry(LeafAw'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, n - 1)));
  endtask

  initial begin
    logic [WeightW-1:0] fa, fb;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty, single leaf, ties, repeated build, saturation, unknown command
    read_entry(8'd0);
    build();
    read_entry(8'd0);
    load(8'hff, 32'hffffffff);
    build();
    read_entry(8'd0);
    read_entry(8'd1);
    load(8'h00, 32'd1);
    load(8'h55, 32'd1);
    load(8'haa, 32'd1);
    build();
    read_entry(8'd0);
    read_entry(8'd2);
    build();
    read_entry(8'd2);
    read_entry(8'hff);
    send(CMD_NONE, 8'h3c, 32'h5a5a5a5a, 8'h0f);
    load(8'h10, 32'hffffffff);
    load(8'h20, 32'hffffffff);
    load(8'h30, 32'd1);
    build();
    for (int unsigned i = 0; i < 3; i++) read_entry(LeafAw'(i));

    // deep chain of Fibonacci weights, saturating near the root
    fa = 1; fb = 1;
    for (int unsigned i = 0; i < 47; i++) begin
      load(SymW'(i), fa);
      {fa, fb} = {fb, (fa + fb < fb) ? 32'hffffffff : fa + fb};
    end
    load(8'hee, 32'hffffffff);
    build();
    for (int unsigned i = 0; i < 48; i++) read_entry(LeafAw'(i));

    // full store plus ignored loads
    for (int unsigned i = 0; i < MaxLeaves + 2; i++)
      load(SymW'($urandom), rand_weight(i % 3));
    build();
    for (int unsigned i = 0; i < 12; i++) read_entry(LeafAw'($urandom));
    read_entry(8'hff);

    while (items_sent < 750)
      random_set(($urandom_range(0, 5) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10));

    in_valid_i <= 1'b0;
    while (sb.code_reads.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d transactions with %0d builds; checked %0d code reads, %0d errors",
             items_sent, builds_sent, sb.reads_checked, sb.errors);
    if (sb.errors == 0 && sb.code_reads.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hcb_pkg.sv
rtl/hcb_ram.sv
rtl/huffman_tree_code_builder_top.sv
tb/tb.sv
